@@ rtl/upq_pkg.sv @@
// Shared types and codes for the unsorted priority queue.
// No dependencies; used by upq_ctrl, upq_datapath and the top level.
package upq_pkg;

  // Default sizes
  localparam int DEPTH_DEF         = 16;
  localparam int TAG_BITS_DEF      = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int KIND_W = 2;
  localparam int STAT_W = 3;

  // Operation kinds
  localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SERVE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UPGRADE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTAG    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTLOWER = 3'd4;

  // Controller -> datapath
  typedef struct packed {
    logic item_load;  // latch accepted word, reset scan
    logic scan_rd;    // read entry at scan pointer, advance
    logic commit;     // apply operation, load result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_scan;  // serve/upgrade on a non-empty queue
    logic rd_last;    // scan pointer at last held entry
    logic out_free;   // result register can take a word
  } stat_t;

endpackage

@@ rtl/upq_ctrl.sv @@
// Sequencer for the unsorted priority queue.
// Depends on upq_pkg (cmd_t, stat_t); drives upq_datapath.
module upq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  upq_pkg::stat_t stat,
  output upq_pkg::cmd_t  cmd
);
  import upq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd.item_load = 1'b0;
    cmd.scan_rd   = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = stat.need_scan ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.rd_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // last read word is folded in this cycle
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/upq_datapath.sv @@
// Entry storage, scan accumulator, front tracking and result register.
// Depends on upq_pkg; sequenced by upq_ctrl.
module upq_datapath #(
  parameter int DEPTH         = upq_pkg::DEPTH_DEF,
  parameter int TAG_BITS      = upq_pkg::TAG_BITS_DEF,
  parameter int PRIORITY_BITS = upq_pkg::PRIORITY_BITS_DEF,
  localparam int CNT_W        = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [upq_pkg::KIND_W-1:0] in_kind,
  input  logic [TAG_BITS-1:0]        in_tag,
  input  logic [PRIORITY_BITS-1:0]   in_priority_req,
  input  upq_pkg::cmd_t              cmd,
  output upq_pkg::stat_t             stat,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [upq_pkg::STAT_W-1:0] out_status,
  output logic [TAG_BITS-1:0]        out_served_tag,
  output logic [TAG_BITS-1:0]        out_front_tag,
  output logic [PRIORITY_BITS-1:0]   out_front_priority,
  output logic                       out_empty_res,
  output logic [CNT_W-1:0]           out_occupancy
);
  import upq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  // entry memories
  logic [TAG_BITS-1:0]      tag_mem [DEPTH];
  logic [PRIORITY_BITS-1:0] pri_mem [DEPTH];

  // latched word
  logic [KIND_W-1:0]        kind_r;
  logic [TAG_BITS-1:0]      tag_r;
  logic [PRIORITY_BITS-1:0] prio_r;

  // queue state
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [TAG_BITS-1:0]      front_tag_r, front_tag_nxt;
  logic [PRIORITY_BITS-1:0] front_pri_r, front_pri_nxt;
  logic [IDX_W-1:0]         front_slot_r, front_slot_nxt;

  // scan pipeline
  logic [IDX_W-1:0]         rd_ptr_r;
  logic                     rd_vld_r;
  logic [IDX_W-1:0]         rd_idx_r;
  logic [TAG_BITS-1:0]      rd_tag_r;
  logic [PRIORITY_BITS-1:0] rd_pri_r;

  // best qualifying entry seen so far
  logic                     acc_found_r;
  logic [TAG_BITS-1:0]      acc_tag_r;
  logic [PRIORITY_BITS-1:0] acc_pri_r;
  logic [IDX_W-1:0]         acc_slot_r;

  // result register
  logic                     out_tvalid_r;
  logic [STAT_W-1:0]        out_status_r;
  logic [TAG_BITS-1:0]      out_served_r;
  logic [TAG_BITS-1:0]      out_ftag_r;
  logic [PRIORITY_BITS-1:0] out_fpri_r;
  logic [CNT_W-1:0]         out_occ_r;

  logic                     is_serve, is_full, is_empty;
  logic                     past_front, qual, acc_take;
  logic [IDX_W-1:0]         new_idx;
  logic                     shift_we, ins_we, upg_we, tag_we, pri_we;
  logic [IDX_W-1:0]         wr_addr;
  logic [TAG_BITS-1:0]      wr_tag;
  logic [PRIORITY_BITS-1:0] wr_pri;
  logic [STAT_W-1:0]        status_c;
  logic [TAG_BITS-1:0]      served_c;

  assign is_serve = (kind_r == KIND_SERVE);
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  assign stat.need_scan = !is_empty && (is_serve || kind_r == KIND_UPGRADE);
  assign stat.rd_last   = ((CNT_W'(rd_ptr_r) + CNT_W'(1)) == count_r);
  assign stat.out_free  = !out_tvalid_r || out_tready;

  // Serve: entries past the removed front move down one slot while scanning.
  assign past_front = (rd_idx_r > front_slot_r);
  assign new_idx    = past_front ? (rd_idx_r - IDX_W'(1)) : rd_idx_r;
  assign qual       = is_serve ? (rd_idx_r != front_slot_r) : (rd_tag_r == tag_r);
  assign acc_take   = rd_vld_r && qual && (!acc_found_r || rd_pri_r < acc_pri_r);

  assign shift_we = rd_vld_r && is_serve && past_front;
  assign ins_we   = cmd.commit && (kind_r == KIND_INSERT) && !is_full;
  assign upg_we   = cmd.commit && (kind_r == KIND_UPGRADE) && acc_found_r &&
                    (prio_r < acc_pri_r);
  assign tag_we   = shift_we || ins_we;
  assign pri_we   = shift_we || ins_we || upg_we;

  always_comb begin
    if (shift_we) begin
      wr_addr = rd_idx_r - IDX_W'(1);
    end else if (ins_we) begin
      wr_addr = count_r[IDX_W-1:0];
    end else begin
      wr_addr = acc_slot_r;
    end
    wr_tag = shift_we ? rd_tag_r : tag_r;
    wr_pri = shift_we ? rd_pri_r : prio_r;
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[wr_addr] <= wr_tag;
    if (pri_we) pri_mem[wr_addr] <= wr_pri;
    if (cmd.scan_rd) begin
      rd_tag_r <= tag_mem[rd_ptr_r];
      rd_pri_r <= pri_mem[rd_ptr_r];
    end
  end

  // operation outcome
  always_comb begin
    count_nxt      = count_r;
    front_tag_nxt  = front_tag_r;
    front_pri_nxt  = front_pri_r;
    front_slot_nxt = front_slot_r;
    status_c       = ST_OK;
    served_c       = '0;
    unique case (kind_r)
      KIND_INSERT: begin
        if (is_full) begin
          status_c = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          // ties keep the earlier front
          if (is_empty || prio_r < front_pri_r) begin
            front_tag_nxt  = tag_r;
            front_pri_nxt  = prio_r;
            front_slot_nxt = count_r[IDX_W-1:0];
          end
        end
      end
      KIND_SERVE: begin
        if (is_empty) begin
          status_c = ST_EMPTY;
        end else begin
          served_c       = front_tag_r;
          count_nxt      = count_r - CNT_W'(1);
          front_tag_nxt  = acc_tag_r;
          front_pri_nxt  = acc_pri_r;
          front_slot_nxt = acc_slot_r;
        end
      end
      KIND_UPGRADE: begin
        if (!acc_found_r) begin
          status_c = ST_NOTAG;
        end else if (prio_r >= acc_pri_r) begin
          status_c = ST_NOTLOWER;
        end else if (prio_r < front_pri_r ||
                     (prio_r == front_pri_r && acc_slot_r < front_slot_r)) begin
          front_tag_nxt  = acc_tag_r;
          front_pri_nxt  = prio_r;
          front_slot_nxt = acc_slot_r;
        end
      end
      default: begin
        count_nxt = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      rd_vld_r     <= 1'b0;
      acc_found_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.item_load) begin
        acc_found_r <= 1'b0;
      end else if (acc_take) begin
        acc_found_r <= 1'b1;
      end
      if (cmd.commit) begin
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      kind_r   <= in_kind;
      tag_r    <= in_tag;
      prio_r   <= in_priority_req;
      rd_ptr_r <= '0;
    end else if (cmd.scan_rd) begin
      rd_ptr_r <= rd_ptr_r + IDX_W'(1);
    end
    if (cmd.scan_rd) rd_idx_r <= rd_ptr_r;
    if (acc_take) begin
      acc_tag_r  <= rd_tag_r;
      acc_pri_r  <= rd_pri_r;
      acc_slot_r <= is_serve ? new_idx : rd_idx_r;
    end
    if (cmd.commit) begin
      front_tag_r  <= front_tag_nxt;
      front_pri_r  <= front_pri_nxt;
      front_slot_r <= front_slot_nxt;
      out_status_r <= status_c;
      out_served_r <= served_c;
      out_ftag_r   <= (count_nxt != '0) ? front_tag_nxt : '0;
      out_fpri_r   <= (count_nxt != '0) ? front_pri_nxt : '0;
      out_occ_r    <= count_nxt;
    end
  end

  assign out_tvalid         = out_tvalid_r;
  assign out_status         = out_status_r;
  assign out_served_tag     = out_served_r;
  assign out_front_tag      = out_ftag_r;
  assign out_front_priority = out_fpri_r;
  assign out_empty_res      = (out_occ_r == '0);
  assign out_occupancy      = out_occ_r;

endmodule

@@ rtl/unsorted_priority_queue.sv @@
// Top level of the unsorted-array min-priority queue.
// Depends on upq_pkg, upq_ctrl and upq_datapath.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  --------+-----+---------------------------------------------+--------
//  in_     | in  | tag, priority_req                           | kind
//  out_    | out | served_tag, front_tag, front_priority,      | status
//          |     | empty_res, occupancy                        |
//
// Insert and clear skip the scan; serve and upgrade on a non-empty queue make one
//   pass over the entry memory through its single read port (one entry per cycle,
//   read data registered).
// Serve closes the gap in the same pass that finds the next front.
// Reset (rst_n low, synchronous) empties the queue; entry memory is not cleared.
// A result waits in the output register while the next word is taken; the
//   block stalls only at commit when that register is still full.
module unsorted_priority_queue #(
  parameter int DEPTH         = upq_pkg::DEPTH_DEF,
  parameter int TAG_BITS      = upq_pkg::TAG_BITS_DEF,
  parameter int PRIORITY_BITS = upq_pkg::PRIORITY_BITS_DEF,
  localparam int CNT_W        = $clog2(DEPTH + 1),
  localparam int IN_W         = ((TAG_BITS + PRIORITY_BITS + 7) / 8) * 8,
  localparam int OUT_W        = ((2 * TAG_BITS + PRIORITY_BITS + 1 + CNT_W + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_W-1:0]            in_tdata,   // tag, priority_req
  input  logic [upq_pkg::KIND_W-1:0] in_tuser,   // kind
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_W-1:0]           out_tdata,  // served_tag, front_tag,
                                                 // front_priority, empty_res,
                                                 // occupancy
  output logic [upq_pkg::STAT_W-1:0] out_tuser   // status
);
  import upq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  logic [TAG_BITS-1:0]      served_tag;
  logic [TAG_BITS-1:0]      front_tag;
  logic [PRIORITY_BITS-1:0] front_priority;
  logic                     empty_res;
  logic [CNT_W-1:0]         occupancy;
  logic [STAT_W-1:0]        status;

  upq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  upq_datapath #(
    .DEPTH         (DEPTH),
    .TAG_BITS      (TAG_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_kind            (in_tuser),
    .in_tag             (in_tdata[TAG_BITS-1:0]),
    .in_priority_req    (in_tdata[TAG_BITS +: PRIORITY_BITS]),
    .cmd                (cmd),
    .stat               (stat),
    .out_tready         (out_tready),
    .out_tvalid         (out_tvalid),
    .out_status         (status),
    .out_served_tag     (served_tag),
    .out_front_tag      (front_tag),
    .out_front_priority (front_priority),
    .out_empty_res      (empty_res),
    .out_occupancy      (occupancy)
  );

  // pack result word, zero fill to whole bytes
  assign out_tdata = OUT_W'({occupancy, empty_res, front_priority, front_tag, served_tag});
  assign out_tuser = status;

  // one word in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word accepted while previous one still in work");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occupancy <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == ST_FULL |-> occupancy == CNT_W'(DEPTH))
    else $error("full reported on a queue with room");

  a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && empty_res |-> front_tag == '0 && front_priority == '0 && served_tag == '0
      || status == ST_OK && served_tag != '0)
    else $error("empty result carries a front entry");

endmodule

@@ tb/unsorted_priority_queue_test.sv @@
// Self-checking testbench for the unsorted_priority_queue block.
// Needs upq_pkg and the RTL of the block; a built-in predictor checks every
// result word under random source gaps and random sink stalls.
module unsorted_priority_queue_test;
  import upq_pkg::*;

  localparam int DEPTH  = DEPTH_DEF;
  localparam int TAG_W  = TAG_BITS_DEF;
  localparam int PRI_W  = PRIORITY_BITS_DEF;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IN_W   = ((TAG_W + PRI_W + 7) / 8) * 8;
  localparam int OUT_W  = ((2 * TAG_W + PRI_W + 1 + CNT_W + 7) / 8) * 8;
  localparam int RANDOM_WORDS = 550;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [PRI_W-1:0]  prio;
  } request_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [TAG_W-1:0]  served_tag;
    logic [TAG_W-1:0]  front_tag;
    logic [PRI_W-1:0]  front_prio;
    logic              empty;
    logic [CNT_W-1:0]  occupancy;
  } report_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0] in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [STAT_W-1:0] out_tuser;

  unsorted_priority_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the queue: slots 0..held_count-1 in arrival order.
  logic [TAG_W-1:0] held_tags  [DEPTH];
  logic [PRI_W-1:0] held_prios [DEPTH];
  int               held_count = 0;

  request_t pending_requests[$];
  report_t  expected_reports[$];

  int mismatch_count = 0;
  int words_in = 0;
  int words_out = 0;
  int status_hits[5] = '{default: 0};

  // Lowest priority value, earliest arrival on a tie; queue must hold entries.
  function automatic int lowest_slot();
    int best;
    int i;
    best = 0;
    for (i = 1; i < held_count; i++)
      if (held_prios[i] < held_prios[best]) best = i;
    return best;
  endfunction

  // Applies one word to the shadow queue and returns the report it should give.
  function automatic report_t apply_request(request_t req);
    report_t rpt;
    int      s;
    int      i;
    bit      found;
    rpt.status = ST_OK;
    rpt.served_tag = '0;
    case (req.kind)
      KIND_INSERT: begin
        if (held_count >= DEPTH) begin
          rpt.status = ST_FULL;
        end else begin
          held_tags[held_count] = req.tag;
          held_prios[held_count] = req.prio;
          held_count++;
        end
      end
      KIND_SERVE: begin
        if (held_count == 0) begin
          rpt.status = ST_EMPTY;
        end else begin
          s = lowest_slot();
          rpt.served_tag = held_tags[s];
          for (i = s; i + 1 < held_count; i++) begin
            held_tags[i] = held_tags[i + 1];
            held_prios[i] = held_prios[i + 1];
          end
          held_count--;
        end
      end
      KIND_UPGRADE: begin
        // best entry carrying the tag; missing tag wins over "not lower"
        found = 1'b0;
        s = 0;
        for (i = 0; i < held_count; i++) begin
          if (held_tags[i] == req.tag && (!found || held_prios[i] < held_prios[s])) begin
            s = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          rpt.status = ST_NOTAG;
        end else if (req.prio >= held_prios[s]) begin
          rpt.status = ST_NOTLOWER;
        end else begin
          held_prios[s] = req.prio;
        end
      end
      default: begin
        held_count = 0;
      end
    endcase
    if (held_count > 0) begin
      s = lowest_slot();
      rpt.front_tag = held_tags[s];
      rpt.front_prio = held_prios[s];
      rpt.empty = 1'b0;
    end else begin
      rpt.front_tag = '0;
      rpt.front_prio = '0;
      rpt.empty = 1'b1;
    end
    rpt.occupancy = CNT_W'(held_count);
    return rpt;
  endfunction

  function automatic void add_request(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                                      logic [PRI_W-1:0] prio);
    request_t req;
    req.kind = kind;
    req.tag = tag;
    req.prio = prio;
    pending_requests.push_back(req);
  endfunction

  // Source side: holds a word until taken, then waits its drawn gap.
  request_t driven_req;
  int       in_gap = 0;
  bit       in_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_reports.push_back(apply_request(driven_req));
        words_in++;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        driven_req = pending_requests.pop_front();
        in_tdata <= {driven_req.prio, driven_req.tag};
        in_tuser <= driven_req.kind;
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 9);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: checks each result word, then stalls for its drawn count.
  int      out_stall = 0;
  bit      out_burst = 1'b0;
  bit      next_ready;
  report_t got;
  report_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        words_out++;
        got.status     = out_tuser;
        got.served_tag = out_tdata[TAG_W-1:0];
        got.front_tag  = out_tdata[2*TAG_W-1:TAG_W];
        got.front_prio = out_tdata[2*TAG_W+PRI_W-1:2*TAG_W];
        got.empty      = out_tdata[2*TAG_W+PRI_W];
        got.occupancy  = out_tdata[2*TAG_W+PRI_W+CNT_W:2*TAG_W+PRI_W+1];
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("tb: result word with none expected: status %0d front %h/%h occ %0d",
                     got.status, got.front_tag, got.front_prio, got.occupancy);
        end else begin
          want = expected_reports.pop_front();
          if (got.status < 5) status_hits[got.status]++;
          if (got.status !== want.status || got.served_tag !== want.served_tag ||
              got.front_tag !== want.front_tag || got.front_prio !== want.front_prio ||
              got.empty !== want.empty || got.occupancy !== want.occupancy) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("tb: word %0d mismatch (expected/actual): status %0d/%0d served %h/%h",
                       words_out, want.status, got.status, want.served_tag, got.served_tag);
              $display("tb:   front %h/%h prio %h/%h empty %b/%b occ %0d/%0d",
                       want.front_tag, got.front_tag, want.front_prio, got.front_prio,
                       want.empty, got.empty, want.occupancy, got.occupancy);
            end
          end
        end
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 9);
      end
      if (out_stall > 0) begin
        out_stall--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_tready <= next_ready;
    end
  end

  initial begin
    int mode;
    int r;
    int i;
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic [PRI_W-1:0]  prio;

    // Directed: empty-queue cases, fill to full with ties and repeated tags,
    // insert on full, upgrade equal / lower / absent, serves, clear.
    add_request(KIND_SERVE, 16'h0000, 8'h00);
    add_request(KIND_UPGRADE, 16'h0005, 8'h01);
    add_request(KIND_CLEAR, 16'hFFFF, 8'hFF);
    add_request(KIND_INSERT, 16'h0000, 8'hFF);
    add_request(KIND_INSERT, 16'hFFFF, 8'h00);
    for (i = 0; i < DEPTH - 2; i++)
      add_request(KIND_INSERT, TAG_W'(32'h1000 + (i % 5)), PRI_W'(32'h10 + (i % 4) * 8));
    add_request(KIND_INSERT, 16'hABCD, 8'h01);
    add_request(KIND_UPGRADE, 16'h1001, 8'h18);
    add_request(KIND_UPGRADE, 16'h1001, 8'h05);
    add_request(KIND_UPGRADE, 16'hBEEF, 8'h00);
    add_request(KIND_SERVE, 16'hFFFF, 8'hFF);
    add_request(KIND_SERVE, 16'h0000, 8'h00);
    add_request(KIND_CLEAR, 16'h0000, 8'h00);

    // Random: phases lean toward filling, draining or mixed traffic so that
    // both the full and the empty queue come up; tags mostly from a small set.
    mode = 0;
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 40 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      case (mode)
        0:       kind = r < 70 ? KIND_INSERT : r < 85 ? KIND_SERVE :
                        r < 98 ? KIND_UPGRADE : KIND_CLEAR;
        1:       kind = r < 15 ? KIND_INSERT : r < 80 ? KIND_SERVE :
                        r < 98 ? KIND_UPGRADE : KIND_CLEAR;
        default: kind = r < 40 ? KIND_INSERT : r < 70 ? KIND_SERVE :
                        r < 97 ? KIND_UPGRADE : KIND_CLEAR;
      endcase
      tag = ($urandom_range(0, 3) == 0) ? TAG_W'($urandom_range(0, 65535))
                                        : TAG_W'($urandom_range(0, 11));
      prio = ($urandom_range(0, 3) == 0) ? PRI_W'($urandom_range(0, 7))
                                         : PRI_W'($urandom_range(0, 255));
      add_request(kind, tag, prio);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_tvalid || expected_reports.size() != 0)
      @(negedge clk);
    // wait on so that any stray word can still show up
    repeat (40) @(negedge clk);

    $display("tb: %0d words sent, %0d results checked, %0d mismatches", words_in, words_out,
             mismatch_count);
    $display("tb: status counts ok %0d, empty %0d, full %0d, no tag %0d, not lower %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: timeout with %0d results outstanding", expected_reports.size());
    $display("tb: failure");
    $finish;
  end

endmodule
